>>> design/assert_macros.svh
// assertion macros for the design files, used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/pbn_pkg.sv
// package: widths, register codes and rounding helper for the pixel blend pipeline
package pbn_pkg;

  localparam int WEIGHT_FRAC_BITS = 8;

  localparam int PIX_W = 8;
  localparam int IW_W = 9;
  localparam int NW_W = 9;
  localparam int GAIN_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W = 2;

  // noise weight after clamping must hold ONE itself
  localparam int WW = (NW_W > WEIGHT_FRAC_BITS + 1) ? NW_W : WEIGHT_FRAC_BITS + 1;
  localparam int IMG_W = PIX_W + 1 + IW_W;
  localparam int MIX_W = PIX_W + WW + 1;
  localparam int GAINP_W = PIX_W + GAIN_W;
  localparam int ACC_W0 = (IMG_W > MIX_W) ? IMG_W : MIX_W;
  localparam int ACC_W = (ACC_W0 > GAINP_W) ? ACC_W0 : GAINP_W;

  localparam logic [WW-1:0] WONE = WW'(1) << WEIGHT_FRAC_BITS;
  localparam logic [WEIGHT_FRAC_BITS-1:0] HALF = {1'b1, {(WEIGHT_FRAC_BITS-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 2'd2;

  localparam logic [IW_W-1:0] IMAGE_WEIGHT_RST = 9'd128;
  localparam logic [NW_W-1:0] NOISE_WEIGHT_RST = 9'd128;
  localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST = 11'd461;

  // drop the fraction bits, round to nearest with ties to even, clip to 255
  function automatic logic [PIX_W-1:0] rne_sat8(input logic [ACC_W-1:0] x);
    logic [ACC_W-1:0] q;
    logic [WEIGHT_FRAC_BITS-1:0] rem;
    logic inc;
    begin
      q = x >> WEIGHT_FRAC_BITS;
      rem = x[WEIGHT_FRAC_BITS-1:0];
      inc = (rem > HALF) || ((rem == HALF) && q[0]);
      q = q + ACC_W'(inc);
      rne_sat8 = (q > ACC_W'(255)) ? {PIX_W{1'b1}} : q[PIX_W-1:0];
    end
  endfunction

endpackage

>>> design/pbn_if.sv
// stream and configuration channel interfaces
interface pbn_in_if import pbn_pkg::*; ();
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel_a;
  logic [PIX_W-1:0] pixel_b;
  logic [PIX_W-1:0] noise_pixel;
  modport source (output valid, output pixel_a, output pixel_b, output noise_pixel,
                  input ready);
  modport sink (input valid, input pixel_a, input pixel_b, input noise_pixel,
                output ready);
endinterface

interface pbn_out_if import pbn_pkg::*; ();
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface

interface pbn_cfg_if import pbn_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/pbn_blend.sv
// four-stage image mix and noise mix
module pbn_blend import pbn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  pixel_a,
  input  logic [PIX_W-1:0]  pixel_b,
  input  logic [PIX_W-1:0]  noise_pixel,
  input  logic [IW_W-1:0]   image_weight,
  input  logic [NW_W-1:0]   noise_weight,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  mix_pixel
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic [IMG_W-1:0] prod1;
  logic [PIX_W-1:0] n1, n2;
  logic [PIX_W-1:0] m2;
  logic [MIX_W-1:0] mix3;
  logic [PIX_W-1:0] v_pix;
  logic [WW-1:0] w;
  logic [PIX_W:0] sum_ab;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  // weights above one clamp to one
  assign w = (WW'(noise_weight) > WONE) ? WONE : WW'(noise_weight);
  assign sum_ab = {1'b0, pixel_a} + {1'b0, pixel_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      prod1 <= IMG_W'(sum_ab) * IMG_W'(image_weight);
      n1 <= noise_pixel;
    end
    if (en2 && v1) begin
      m2 <= rne_sat8(ACC_W'(prod1));
      n2 <= n1;
    end
    if (en3 && v2) begin
      mix3 <= MIX_W'(m2) * MIX_W'(WONE - w) + MIX_W'(n2) * MIX_W'(w);
    end
    if (en4 && v3) begin
      v_pix <= rne_sat8(ACC_W'(mix3));
    end
  end

  assign out_valid = v4;
  assign mix_pixel = v_pix;

endmodule

>>> design/pbn_curve.sv
// two-stage square curve, round(v*v/255)
module pbn_curve import pbn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  mix_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  curve_pixel
);

  logic v1, v2;
  logic en1, en2;
  logic [15:0] sq;
  logic [15:0] x1;
  logic [23:0] x257;
  logic [7:0] q0;
  logic [15:0] r;
  logic [PIX_W-1:0] c2;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign sq = {8'd0, mix_pixel} * {8'd0, mix_pixel};

  // x*257 >> 16 is the quotient by 255 or one short of it
  assign x257 = {8'd0, x1} + {x1, 8'd0};
  assign q0 = x257[23:16];
  assign r = x1 - ({q0, 8'd0} - {8'd0, q0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    // adding 127 turns round to nearest into a floor, no ties with an odd divisor
    if (en1 && in_valid) x1 <= sq + 16'd127;
    if (en2 && v1) c2 <= (r >= 16'd255) ? q0 + 8'd1 : q0;
  end

  assign out_valid = v2;
  assign curve_pixel = c2;

endmodule

>>> design/pbn_gain.sv
// two-stage gain multiply with rounding and saturation
module pbn_gain import pbn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  curve_pixel,
  input  logic [GAIN_W-1:0] output_gain,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  pixel_out
);

  logic v1, v2;
  logic en1, en2;
  logic [GAINP_W-1:0] prod1;
  logic [PIX_W-1:0] p2;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) prod1 <= GAINP_W'(curve_pixel) * GAINP_W'(output_gain);
    if (en2 && v1) p2 <= rne_sat8(ACC_W'(prod1));
  end

  assign out_valid = v2;
  assign pixel_out = p2;

endmodule

>>> design/pixel_blend_noise_curve_gain_top.sv
// top level: config registers and the eight-stage blend, curve and gain pipeline
`include "assert_macros.svh"

// Grey pixel blend pipeline. Each word carries pixel_a, pixel_b and noise_pixel and
// yields one pixel_out: the two image pixels are mixed with image_weight, that mix is
// blended with the noise pixel by noise_weight, passed through a square curve and
// scaled by output_gain, all with round-half-even and saturation to 0..255.
// Throughput is one pixel per clock unless the output stalls; there are eight
// register stages (four for the mixes, two for the curve, two for the gain), the
// last of which is the output register. A stall at the output backs up stage by
// stage, so empty stages keep filling. Configuration writes are always accepted and
// take effect at once; write them only while the pipeline is empty. Writes to an
// index past the gain register are dropped.
module pixel_blend_noise_curve_gain_top import pbn_pkg::*; (
  input  logic clk,
  input  logic rst,
  pbn_in_if.sink    pix_in,
  pbn_out_if.source pix_out,
  pbn_cfg_if.sink   cfg
);

  logic [IW_W-1:0] image_weight;
  logic [NW_W-1:0] noise_weight;
  logic [GAIN_W-1:0] output_gain;

  logic blend_valid, blend_ready;
  logic [PIX_W-1:0] mix_pixel;
  logic curve_valid, curve_ready;
  logic [PIX_W-1:0] curve_pixel;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_weight <= IMAGE_WEIGHT_RST;
      noise_weight <= NOISE_WEIGHT_RST;
      output_gain <= OUTPUT_GAIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WEIGHT: image_weight <= cfg.data[IW_W-1:0];
        REG_NOISE_WEIGHT: noise_weight <= cfg.data[NW_W-1:0];
        REG_OUTPUT_GAIN:  output_gain <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  pbn_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pix_in.valid),
    .in_ready     (pix_in.ready),
    .pixel_a      (pix_in.pixel_a),
    .pixel_b      (pix_in.pixel_b),
    .noise_pixel  (pix_in.noise_pixel),
    .image_weight (image_weight),
    .noise_weight (noise_weight),
    .out_valid    (blend_valid),
    .out_ready    (blend_ready),
    .mix_pixel    (mix_pixel)
  );

  pbn_curve u_curve (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (blend_valid),
    .in_ready    (blend_ready),
    .mix_pixel   (mix_pixel),
    .out_valid   (curve_valid),
    .out_ready   (curve_ready),
    .curve_pixel (curve_pixel)
  );

  pbn_gain u_gain (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (curve_valid),
    .in_ready    (curve_ready),
    .curve_pixel (curve_pixel),
    .output_gain (output_gain),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .pixel_out   (pix_out.pixel_out)
  );

  // input only backs up when the output word is held
  `ASSERT_CLK(a_stall_from_output, !pix_in.ready |-> (pix_out.valid && !pix_out.ready), "input stalled with output free")
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !pix_out.valid, "output valid right after reset")
  `ASSERT_CLK(a_iw_hold, !(cfg.valid && (cfg.index == REG_IMAGE_WEIGHT)) |=> $stable(image_weight), "image weight changed without a write")

endmodule

>>> test/pixel_out_checker.sv
// checker: follows register writes, predicts each output pixel and compares in order
`timescale 1ns / 1ps

module pixel_out_checker import pbn_pkg::*; (
  input  logic clk,
  input  logic rst,
  pbn_in_if    pix_in,
  pbn_out_if   pix_out,
  pbn_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding
);

  localparam int FB = WEIGHT_FRAC_BITS;
  localparam logic [31:0] ONE = 32'd1 << FB;
  localparam logic [31:0] HALF_LSB = 32'd1 << (FB - 1);

  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] n;
    logic [PIX_W-1:0] pix;
  } blend_word_t;

  logic [IW_W-1:0]   image_wt = IMAGE_WEIGHT_RST;
  logic [NW_W-1:0]   noise_wt = NOISE_WEIGHT_RST;
  logic [GAIN_W-1:0] gain     = OUTPUT_GAIN_RST;

  blend_word_t pixels_due[$];
  blend_word_t head;

  // drop the fraction bits, nearest with ties to even
  function automatic logic [31:0] round_frac(input logic [31:0] x);
    logic [31:0] q;
    logic [31:0] r;
    q = x >> FB;
    r = x & (ONE - 32'd1);
    if (r > HALF_LSB || (r == HALF_LSB && q[0])) q = q + 32'd1;
    return q;
  endfunction

  function automatic logic [31:0] clip8(input logic [31:0] x);
    return (x > 32'd255) ? 32'd255 : x;
  endfunction

  function automatic logic [PIX_W-1:0] blended_pixel(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b,
                                                     input logic [PIX_W-1:0] n);
    logic [31:0] w, m, v, sq, c, p;
    w = (32'(noise_wt) > ONE) ? ONE : 32'(noise_wt);
    m = clip8(round_frac((32'(a) + 32'(b)) * 32'(image_wt)));
    v = clip8(round_frac(m * (ONE - w) + 32'(n) * w));
    // square curve, quotient by 255 rounded to nearest
    sq = v * v;
    c = sq / 32'd255;
    if (32'd2 * (sq % 32'd255) > 32'd255) c = c + 32'd1;
    p = clip8(round_frac(c * 32'(gain)));
    return p[PIX_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      image_wt = IMAGE_WEIGHT_RST;
      noise_wt = NOISE_WEIGHT_RST;
      gain     = OUTPUT_GAIN_RST;
      pixels_due.delete();
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (pixels_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected pixel_out %0d", $time, pix_out.pixel_out);
          fail_count++;
        end else begin
          head = pixels_due.pop_front();
          if (pix_out.pixel_out !== head.pix) begin
            if (fail_count < 10)
              $display("%0t: pixel_out mismatch a=%0d b=%0d n=%0d: expected %0d, got %0d",
                       $time, head.a, head.b, head.n, head.pix, pix_out.pixel_out);
            fail_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_WEIGHT: image_wt = cfg.data[IW_W-1:0];
          REG_NOISE_WEIGHT: noise_wt = cfg.data[NW_W-1:0];
          REG_OUTPUT_GAIN:  gain     = cfg.data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready)
        pixels_due.insert(pixels_due.size(),
                          '{pix_in.pixel_a, pix_in.pixel_b, pix_in.noise_pixel,
                            blended_pixel(pix_in.pixel_a, pix_in.pixel_b,
                                          pix_in.noise_pixel)});
    end
    outstanding = pixels_due.size();
  end

endmodule

>>> test/tb_pixel_blend_noise_curve_gain_top.sv
// testbench top: clock, reset, register phases, pixel stimulus and verdict
`timescale 1ns / 1ps

module tb_pixel_blend_noise_curve_gain_top;
  import pbn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_AT_RESULT = 250;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN_CYCLES = 12;

  // {pixel_a, pixel_b, noise_pixel}
  localparam logic [23:0] DIRECTED_WORDS [0:17] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h010000,
    24'h030000, 24'hFFFF00, 24'h808080, 24'h010203, 24'h55AA55, 24'hC8C907,
    24'hFE01FE, 24'h7F8001, 24'h4040C8, 24'h0A0B0C, 24'h00FFFF, 24'hAA55AA
  };

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   pixels_sent;
  int   results_taken;

  pbn_in_if  pix_in();
  pbn_out_if pix_out();
  pbn_cfg_if cfg();

  pixel_blend_noise_curve_gain_top dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  pixel_out_checker out_check (
    .clk         (clk),
    .rst         (rst),
    .pix_in      (pix_in),
    .pix_out     (pix_out),
    .cfg         (cfg),
    .fail_count  (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_pixel_blend_noise_curve_gain_top: done, errors");
    $finish;
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic load_weights(input logic [CFG_DATA_W-1:0] iw,
                              input logic [CFG_DATA_W-1:0] nw,
                              input logic [CFG_DATA_W-1:0] g);
    write_reg(REG_IMAGE_WEIGHT, iw);
    write_reg(REG_NOISE_WEIGHT, nw);
    write_reg(REG_OUTPUT_GAIN, g);
  endtask

  task automatic offer_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                             input logic [PIX_W-1:0] n);
    int gap;
    // every fourth stretch of words goes back to back
    gap = ((pixels_sent / 150) % 4 == 2) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      pix_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in.valid       = 1'b1;
    pix_in.pixel_a     = a;
    pix_in.pixel_b     = b;
    pix_in.noise_pixel = n;
    do @(posedge clk); while (!pix_in.ready);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic random_pixels(input int count);
    for (int i = 0; i < count; i++)
      offer_pixel(pick_pixel(), pick_pixel(), pick_pixel());
    pix_in.valid = 1'b0;
  endtask

  task automatic wait_drained();
    pix_in.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off to back the pipeline up
  initial begin
    int stall;
    pix_out.ready = 1'b0;
    results_taken = 0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (results_taken == HOLD_AT_RESULT) begin
        pix_out.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = ((results_taken / 170) % 4 == 1) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        pix_out.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pix_out.ready = 1'b1;
      do @(posedge clk); while (!pix_out.valid);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    pixels_sent = 0;
    pix_in.valid = 1'b0;
    pix_in.pixel_a = '0;
    pix_in.pixel_b = '0;
    pix_in.noise_pixel = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset weights: ties in the image mix, gain overflow, field extremes
    foreach (DIRECTED_WORDS[i])
      offer_pixel(DIRECTED_WORDS[i][23:16], DIRECTED_WORDS[i][15:8], DIRECTED_WORDS[i][7:0]);
    random_pixels(480);
    wait_drained();

    load_weights(11'd256, 11'd0, 11'd256);
    random_pixels(120);
    wait_drained();

    load_weights(11'd0, 11'd256, 11'd2047);
    random_pixels(120);
    wait_drained();

    // upper data bits get masked off
    load_weights(11'h7FF, 11'h7FF, 11'd0);
    random_pixels(120);
    wait_drained();

    load_weights(11'd200, 11'd64, 11'd700);
    write_reg(REG_UNUSED, 11'h7FF);
    random_pixels(120);
    wait_drained();

    // noise weight past one clamps
    load_weights(11'd300, 11'd400, 11'd300);
    random_pixels(120);
    wait_drained();

    repeat (3) begin
      load_weights(CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 2047)),
                   CFG_DATA_W'($urandom_range(0, 2047)));
      random_pixels(120);
      wait_drained();
    end

    if (errors == 0 && outstanding == 0) begin
      $display("tb_pixel_blend_noise_curve_gain_top: done, clean");
    end else begin
      $display("tb_pixel_blend_noise_curve_gain_top: done, errors");
    end
    $finish;
  end

endmodule
